// ===== rtl/indexed_min_heap_queue_macros.svh =====
// Assertion macros shared by the checker of the heap queue.
// Each expects signals named clk and arst_n in the scope where it is used.
`ifndef INDEXED_MIN_HEAP_QUEUE_MACROS_SVH
`define INDEXED_MIN_HEAP_QUEUE_MACROS_SVH

// Same-cycle implication.
`define HQ_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define HQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/hq_pkg.sv =====
`default_nettype none

package hq_pkg;

	localparam int CAPACITY = 256;
	localparam int HANDLES  = 256;
	localparam int HANDLE_W = 8;
	localparam int KEY_W    = 32;
	localparam int CNT_W    = 9;
	localparam int IDX_W    = $clog2(CAPACITY);

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_MODIFY = 2'd1,
		MODE_DELETE = 2'd2,
		MODE_POP    = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_FULL    = 3'd1,
		ST_ABSENT  = 3'd2,
		ST_EMPTY   = 3'd3,
		ST_PRESENT = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FIND,
		S_DEL_OLD,
		S_DEL_LAST,
		S_POP_TOP,
		S_POP_LAST,
		S_RISE_CHK,
		S_RISE_LD,
		S_RISE_CMP,
		S_SINK_CHK,
		S_SINK_L,
		S_SINK_R,
		S_SINK_CMP,
		S_TOP,
		S_RESULT
	} state_t;

	// heap read address selection
	typedef enum logic [2:0] {
		HA_FOUND,
		HA_PARENT,
		HA_LEFT,
		HA_RIGHT,
		HA_LAST,
		HA_ROOT
	} haddr_t;

	typedef enum logic [1:0] {
		HW_NONE,
		HW_CAND,
		HW_MOV
	} hwr_t;

	typedef enum logic [1:0] {
		MOV_HOLD,
		MOV_REQ,
		MOV_RD
	} mov_t;

	typedef enum logic [1:0] {
		POS_HOLD,
		POS_FOUND,
		POS_NEW,
		POS_ROOT
	} posop_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC
	} cnt_t;

	typedef enum logic [1:0] {
		CLR_NONE,
		CLR_REQ,
		CLR_RD
	} clr_t;

	typedef enum logic [1:0] {
		CAND_HOLD,
		CAND_PARENT,
		CAND_LEFT,
		CAND_RIGHT_MIN
	} cand_t;

	typedef struct packed {
		logic    load;
		logic    hrd;
		haddr_t  ha;
		hwr_t    hw;
		mov_t    mov;
		posop_t  posop;
		cnt_t    cnt;
		clr_t    clr;
		cand_t   cand;
		logic    set_status;
		status_t status;
		logic    take_pop;
		logic    oldk_ld;
		logic    out_ld;
	} hq_cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  up;
		logic  found;
		logic  found_last;
		logic  full;
		logic  empty;
		logic  pos_gt1;
		logic  left_ok;
		logic  right_ok;
		logic  cand_gt_mov;
		logic  mov_gt_cand;
		logic  oldk_gt_rd;
		logic  out_free;
	} hq_stat_t;

endpackage

`default_nettype wire

// ===== rtl/hq_req_if.sv =====
`default_nettype none

interface hq_req_if import hq_pkg::*;;
	logic                valid;
	logic                ready;
	logic [1:0]          mode;
	logic [HANDLE_W-1:0] handle;
	logic [KEY_W-1:0]    key;
	logic                move_up;

	modport source (output valid, output mode, output handle, output key, output move_up,
		input ready);
	modport sink (input valid, input mode, input handle, input key, input move_up,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/hq_rsp_if.sv =====
`default_nettype none

interface hq_rsp_if import hq_pkg::*;;
	logic                valid;
	logic                ready;
	logic [2:0]          status;
	logic [HANDLE_W-1:0] popped_handle;
	logic [KEY_W-1:0]    popped_key;
	logic [CNT_W-1:0]    entry_count;
	logic                top_valid;
	logic [HANDLE_W-1:0] top_handle;
	logic [KEY_W-1:0]    top_key;

	modport source (output valid, output status, output popped_handle, output popped_key,
		output entry_count, output top_valid, output top_handle, output top_key,
		input ready);
	modport sink (input valid, input status, input popped_handle, input popped_key,
		input entry_count, input top_valid, input top_handle, input top_key,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/hq_ctrl.sv =====
`default_nettype none

module hq_ctrl import hq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  hq_stat_t stat,
	output hq_cmd_t  cmd
);

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_nx = S_FIND;
			end
			S_FIND: begin
				unique case (stat.mode)
					MODE_INSERT: begin
						if (stat.found || stat.full) state_nx = S_TOP;
						else state_nx = S_RISE_CHK;
					end
					MODE_MODIFY: begin
						if (!stat.found) state_nx = S_TOP;
						else if (stat.up) state_nx = S_RISE_CHK;
						else state_nx = S_SINK_CHK;
					end
					MODE_DELETE: begin
						if (!stat.found || stat.found_last) state_nx = S_TOP;
						else state_nx = S_DEL_OLD;
					end
					MODE_POP: begin
						if (stat.empty) state_nx = S_TOP;
						else state_nx = S_POP_TOP;
					end
				endcase
			end
			S_DEL_OLD:  state_nx = S_DEL_LAST;
			S_DEL_LAST: state_nx = stat.oldk_gt_rd ? S_RISE_CHK : S_SINK_CHK;
			S_POP_TOP:  state_nx = stat.empty ? S_TOP : S_POP_LAST;
			S_POP_LAST: state_nx = S_SINK_CHK;
			S_RISE_CHK: state_nx = stat.pos_gt1 ? S_RISE_LD : S_TOP;
			S_RISE_LD:  state_nx = S_RISE_CMP;
			S_RISE_CMP: state_nx = stat.cand_gt_mov ? S_RISE_CHK : S_TOP;
			S_SINK_CHK: state_nx = stat.left_ok ? S_SINK_L : S_TOP;
			S_SINK_L:   state_nx = stat.right_ok ? S_SINK_R : S_SINK_CMP;
			S_SINK_R:   state_nx = S_SINK_CMP;
			S_SINK_CMP: state_nx = stat.mov_gt_cand ? S_SINK_CHK : S_TOP;
			S_TOP:      state_nx = S_RESULT;
			S_RESULT: begin
				if (stat.out_free) state_nx = S_IDLE;
			end
			default:    state_nx = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd        = '0;
		cmd.ha     = HA_ROOT;
		cmd.hw     = HW_NONE;
		cmd.mov    = MOV_HOLD;
		cmd.posop  = POS_HOLD;
		cmd.cnt    = CNT_HOLD;
		cmd.clr    = CLR_NONE;
		cmd.cand   = CAND_HOLD;
		cmd.status = ST_OK;
		in_ready   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_FIND: begin
				unique case (stat.mode)
					MODE_INSERT: begin
						if (stat.found) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_PRESENT;
						end else if (stat.full) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_FULL;
						end else begin
							cmd.cnt   = CNT_INC;
							cmd.posop = POS_NEW;
							cmd.mov   = MOV_REQ;
						end
					end
					MODE_MODIFY: begin
						if (!stat.found) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_ABSENT;
						end else begin
							cmd.mov   = MOV_REQ;
							cmd.posop = POS_FOUND;
						end
					end
					MODE_DELETE: begin
						if (!stat.found) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_ABSENT;
						end else begin
							cmd.posop = POS_FOUND;
							cmd.cnt   = CNT_DEC;
							cmd.clr   = CLR_REQ;
							cmd.hrd   = 1'b1;
							cmd.ha    = HA_FOUND;
						end
					end
					MODE_POP: begin
						if (stat.empty) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_EMPTY;
						end else begin
							cmd.hrd = 1'b1;
							cmd.ha  = HA_ROOT;
							cmd.cnt = CNT_DEC;
						end
					end
				endcase
			end
			S_DEL_OLD: begin
				cmd.oldk_ld = 1'b1;
				cmd.hrd     = 1'b1;
				cmd.ha      = HA_LAST;
			end
			S_DEL_LAST: begin
				cmd.mov = MOV_RD;
			end
			S_POP_TOP: begin
				cmd.take_pop = 1'b1;
				cmd.clr      = CLR_RD;
				cmd.hrd      = !stat.empty;
				cmd.ha       = HA_LAST;
			end
			S_POP_LAST: begin
				cmd.mov   = MOV_RD;
				cmd.posop = POS_ROOT;
			end
			S_RISE_CHK: begin
				if (stat.pos_gt1) begin
					cmd.hrd = 1'b1;
					cmd.ha  = HA_PARENT;
				end else begin
					cmd.hw = HW_MOV;
				end
			end
			S_RISE_LD: begin
				cmd.cand = CAND_PARENT;
			end
			S_RISE_CMP: begin
				cmd.hw = stat.cand_gt_mov ? HW_CAND : HW_MOV;
			end
			S_SINK_CHK: begin
				if (stat.left_ok) begin
					cmd.hrd = 1'b1;
					cmd.ha  = HA_LEFT;
				end else begin
					cmd.hw = HW_MOV;
				end
			end
			S_SINK_L: begin
				cmd.cand = CAND_LEFT;
				cmd.hrd  = stat.right_ok;
				cmd.ha   = HA_RIGHT;
			end
			S_SINK_R: begin
				cmd.cand = CAND_RIGHT_MIN;
			end
			S_SINK_CMP: begin
				cmd.hw = stat.mov_gt_cand ? HW_CAND : HW_MOV;
			end
			S_TOP: begin
				cmd.hrd = 1'b1;
				cmd.ha  = HA_ROOT;
			end
			S_RESULT: begin
				cmd.out_ld = stat.out_free;
			end
			default: begin
				cmd.load = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/hq_dpath.sv =====
`default_nettype none

module hq_dpath import hq_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  hq_cmd_t             cmd,
	output hq_stat_t            stat,
	input  logic [1:0]          in_mode,
	input  logic [HANDLE_W-1:0] in_handle,
	input  logic [KEY_W-1:0]    in_key,
	input  logic                in_move_up,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [2:0]          out_status,
	output logic [HANDLE_W-1:0] out_popped_handle,
	output logic [KEY_W-1:0]    out_popped_key,
	output logic [CNT_W-1:0]    out_entry_count,
	output logic                out_top_valid,
	output logic [HANDLE_W-1:0] out_top_handle,
	output logic [KEY_W-1:0]    out_top_key
);

	typedef struct packed {
		logic [HANDLE_W-1:0] h;
		logic [KEY_W-1:0]    k;
	} slot_t;

	// heap slots (slot n at index n-1) and handle position table
	slot_t            heap_mem [CAPACITY];
	logic [CNT_W-1:0] pos_mem  [HANDLES];
	logic [HANDLES-1:0] pos_vld_q;

	mode_t               mode_q;
	logic [HANDLE_W-1:0] h_q;
	logic [KEY_W-1:0]    k_q;
	logic                up_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    pos_q;
	slot_t               mov_q;
	slot_t               cand_q;
	logic [CNT_W-1:0]    cand_pos_q;
	logic [KEY_W-1:0]    oldk_q;
	status_t             status_q;
	logic [HANDLE_W-1:0] ph_q;
	logic [KEY_W-1:0]    pk_q;
	slot_t               rd_q;
	logic [CNT_W-1:0]    pm_rd_q;
	logic                pmv_q;
	logic                out_valid_q;

	logic [CNT_W:0]      rd_slot;
	logic [IDX_W-1:0]    rd_idx;
	logic [IDX_W-1:0]    wr_idx;
	slot_t               wr_data;
	logic                wr_en;
	logic [CNT_W:0]      left_slot;
	logic [CNT_W:0]      right_slot;
	logic [CNT_W-1:0]    slot_one;
	logic [CNT_W:0]      slot_one_w;

	assign slot_one   = CNT_W'(1);
	assign slot_one_w = (CNT_W+1)'(1);
	assign left_slot  = {pos_q, 1'b0};
	assign right_slot = {pos_q, 1'b1};

	always_comb begin
		case (cmd.ha)
			HA_FOUND:  rd_slot = {1'b0, pm_rd_q};
			HA_PARENT: rd_slot = {2'b00, pos_q[CNT_W-1:1]};
			HA_LEFT:   rd_slot = left_slot;
			HA_RIGHT:  rd_slot = right_slot;
			HA_LAST:   rd_slot = {1'b0, count_q} + slot_one_w;
			default:   rd_slot = slot_one_w;
		endcase
	end

	assign rd_idx  = IDX_W'(rd_slot - slot_one_w);
	assign wr_idx  = IDX_W'(pos_q - slot_one);
	assign wr_en   = (cmd.hw != HW_NONE);
	assign wr_data = (cmd.hw == HW_CAND) ? cand_q : mov_q;

	// memories
	always_ff @(posedge clk) begin
		if (wr_en) begin
			heap_mem[wr_idx]  <= wr_data;
			pos_mem[wr_data.h] <= pos_q;
		end
		if (cmd.hrd) rd_q <= heap_mem[rd_idx];
		if (cmd.load) pm_rd_q <= pos_mem[in_handle];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_vld_q   <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (cmd.clr)
				CLR_REQ: pos_vld_q[h_q]    <= 1'b0;
				CLR_RD:  pos_vld_q[rd_q.h] <= 1'b0;
				default: ;
			endcase
			if (wr_en) pos_vld_q[wr_data.h] <= 1'b1;
			case (cmd.cnt)
				CNT_INC: count_q <= count_q + slot_one;
				CNT_DEC: count_q <= count_q - slot_one;
				default: ;
			endcase
			if (cmd.out_ld) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q   <= mode_t'(in_mode);
			h_q      <= in_handle;
			k_q      <= in_key;
			up_q     <= in_move_up;
			pmv_q    <= pos_vld_q[in_handle];
			status_q <= ST_OK;
			ph_q     <= '0;
			pk_q     <= '0;
		end
		if (cmd.set_status) status_q <= cmd.status;
		if (cmd.take_pop) begin
			ph_q <= rd_q.h;
			pk_q <= rd_q.k;
		end
		if (cmd.oldk_ld) oldk_q <= rd_q.k;
		case (cmd.mov)
			MOV_REQ: mov_q <= '{h: h_q, k: k_q};
			MOV_RD:  mov_q <= rd_q;
			default: ;
		endcase
		case (cmd.cand)
			CAND_PARENT: begin
				cand_q     <= rd_q;
				cand_pos_q <= {1'b0, pos_q[CNT_W-1:1]};
			end
			CAND_LEFT: begin
				cand_q     <= rd_q;
				cand_pos_q <= left_slot[CNT_W-1:0];
			end
			CAND_RIGHT_MIN: begin
				if (cand_q.k > rd_q.k) begin
					cand_q     <= rd_q;
					cand_pos_q <= right_slot[CNT_W-1:0];
				end
			end
			default: ;
		endcase
		case (cmd.posop)
			POS_FOUND: pos_q <= pm_rd_q;
			POS_NEW:   pos_q <= count_q + slot_one;
			POS_ROOT:  pos_q <= slot_one;
			default: begin
				if (cmd.hw == HW_CAND) pos_q <= cand_pos_q;
			end
		endcase
		if (cmd.out_ld) begin
			out_status        <= status_q;
			out_popped_handle <= ph_q;
			out_popped_key    <= pk_q;
			out_entry_count   <= count_q;
			out_top_valid     <= (count_q != '0);
			out_top_handle    <= (count_q != '0) ? rd_q.h : '0;
			out_top_key       <= (count_q != '0) ? rd_q.k : '0;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		stat.mode        = mode_q;
		stat.up          = up_q;
		stat.found       = pmv_q && (pm_rd_q != '0) && (pm_rd_q <= count_q);
		stat.found_last  = (pm_rd_q == count_q);
		stat.full        = (count_q == CNT_W'(CAPACITY));
		stat.empty       = (count_q == '0);
		stat.pos_gt1     = (pos_q > slot_one);
		stat.left_ok     = (left_slot <= {1'b0, count_q});
		stat.right_ok    = (right_slot <= {1'b0, count_q});
		stat.cand_gt_mov = (cand_q.k > mov_q.k);
		stat.mov_gt_cand = (mov_q.k > cand_q.k);
		stat.oldk_gt_rd  = (oldk_q > rd_q.k);
		stat.out_free    = !out_valid_q || out_ready;
	end

endmodule

`default_nettype wire

// ===== rtl/indexed_min_heap_queue.sv =====
// Indexed binary min-heap priority queue of up to 256 (handle, key) entries.
// req channel: one request per operation (mode, handle, key, move_up);
//   insert, modify key, delete by handle, or pop the smallest key.
// rsp channel: exactly one result per request, in request order, with a
//   status code, the popped entry (zero unless a pop succeeded), the entry
//   count and the root entry after the operation.
// One request is in flight at a time: req.ready is high only while the
//   sequencer is idle, and a result may still wait in the output register.
// Rejected requests go straight to the result. Insert and modify toward the
//   root rise one level per parent compare; delete of any entry but the last
//   reads that entry and the last one, then rises or sinks; pop reads the
//   root and the last entry, then sinks; modify toward the leaves sinks one
//   level per child compare. A walk stops on a compare or at the root or a
//   leaf. A full heap has 9 levels; req.ready rises with rsp.valid.
// A stalled receiver holds the result in the output register; the block
//   finishes its current request and waits there before going idle.
// Reset clears the handle valid bits and the count at once; the heap slot
//   memory needs no clearing pass: slots beyond the count never reach rsp.
`default_nettype none

module indexed_min_heap_queue import hq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	hq_req_if.sink   req,
	hq_rsp_if.source rsp
);

	hq_cmd_t  cmd;
	hq_stat_t stat;

	// sequencer: walks at most one path between root and leaf per request
	hq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// heap memory, position table and working registers
	hq_dpath u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.in_mode           (req.mode),
		.in_handle         (req.handle),
		.in_key            (req.key),
		.in_move_up        (req.move_up),
		.out_valid         (rsp.valid),
		.out_ready         (rsp.ready),
		.out_status        (rsp.status),
		.out_popped_handle (rsp.popped_handle),
		.out_popped_key    (rsp.popped_key),
		.out_entry_count   (rsp.entry_count),
		.out_top_valid     (rsp.top_valid),
		.out_top_handle    (rsp.top_handle),
		.out_top_key       (rsp.top_key)
	);

endmodule

`default_nettype wire

// ===== rtl/hq_checker.sv =====
`default_nettype none
`include "indexed_min_heap_queue_macros.svh"

module hq_checker import hq_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                req_valid,
	input wire logic                req_ready,
	input wire logic                rsp_valid,
	input wire logic                rsp_ready,
	input wire logic [2:0]          rsp_status,
	input wire logic [HANDLE_W-1:0] popped_handle,
	input wire logic [KEY_W-1:0]    popped_key,
	input wire logic [CNT_W-1:0]    entry_count,
	input wire logic                top_valid,
	input wire logic [KEY_W-1:0]    top_key
);

	`HQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(entry_count) && $stable(top_key), "result changed while stalled")
	`HQ_ASSERT_IMP(a_top_count, rsp_valid, top_valid == (entry_count != '0), "top valid disagrees with count")
	`HQ_ASSERT_IMP(a_pop_zero, rsp_valid && rsp_status != ST_OK, popped_handle == '0 && popped_key == '0, "popped fields set on failed request")
	`HQ_ASSERT_NEXT(a_busy, req_valid && req_ready, !req_ready, "request taken while busy")

endmodule

bind indexed_min_heap_queue hq_checker u_hq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_status    (rsp.status),
	.popped_handle (rsp.popped_handle),
	.popped_key    (rsp.popped_key),
	.entry_count   (rsp.entry_count),
	.top_valid     (rsp.top_valid),
	.top_key       (rsp.top_key)
);

`default_nettype wire
